[hdl/tsdt_pkg.sv]
// ----------------------------------------------------------------------------
// tsdt_pkg
// Types and constants shared by the turn stalk debounce tapper.
// ----------------------------------------------------------------------------
package tsdt_pkg;

  localparam int unsigned QuietW    = 8;
  localparam int unsigned CooldownW = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [QuietW-1:0]    DebounceReset = 8'd25;
  localparam logic [CooldownW-1:0] CooldownReset = 16'd250;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_COOLDOWN = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIR_NEUTRAL = 2'd0,
    DIR_LEFT    = 2'd1,
    DIR_RIGHT   = 2'd2
  } dir_e;

  typedef struct packed {
    logic raw_left;
    logic raw_right;
    logic raw_hold;
  } in_item_t;

  typedef struct packed {
    logic       tap_left;
    logic       tap_right;
    logic       hold_pressed;
    logic [1:0] direction;
  } out_item_t;

  // Debouncer view after the current tick.
  typedef struct packed {
    logic stable;  // stable level, 1 = released
    logic fall;    // stable level just fell to pressed
  } deb_status_t;

endpackage

[hdl/tsdt_debounce.sv]
// ----------------------------------------------------------------------------
// tsdt_debounce
// Quiet-tick debouncer for one active-low contact.
// ----------------------------------------------------------------------------
module tsdt_debounce
  import tsdt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic              raw_i,
  input  logic [QuietW-1:0] debounce_ticks_i,
  output deb_status_t       status_o
);

  logic              stable_q, stable_d;
  logic              prev_q, prev_d;
  logic [QuietW-1:0] quiet_q, quiet_d;
  logic              accept;

  always_comb begin
    if (raw_i != prev_q) begin
      quiet_d = '0;
    end else if (quiet_q != {QuietW{1'b1}}) begin
      quiet_d = quiet_q + 1'b1;
    end else begin
      quiet_d = quiet_q;
    end
    prev_d   = raw_i;
    accept   = (quiet_d > debounce_ticks_i) && (raw_i != stable_q);
    stable_d = accept ? raw_i : stable_q;
    status_o.stable = stable_d;
    status_o.fall   = accept && !raw_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      prev_q   <= 1'b1;
      quiet_q  <= '0;
    end else if (advance_i) begin
      stable_q <= stable_d;
      prev_q   <= prev_d;
      quiet_q  <= quiet_d;
    end
  end

endmodule

[hdl/tsdt_direction.sv]
// ----------------------------------------------------------------------------
// tsdt_direction
// Direction latch, neutral-return cooldown and tap generation.
// ----------------------------------------------------------------------------
module tsdt_direction
  import tsdt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  deb_status_t          left_i,
  input  deb_status_t          right_i,
  input  logic [CooldownW-1:0] cooldown_ticks_i,
  output logic                 tap_left_o,
  output logic                 tap_right_o,
  output dir_e                 direction_o
);

  dir_e                 dir_q, dir_d, dir_edge;
  logic [CooldownW-1:0] since_q, since_d, since_inc;
  logic                 neutral;

  always_comb begin
    since_inc = (since_q != {CooldownW{1'b1}}) ? since_q + 1'b1 : since_q;

    // right wins when both sides fall in the same tick
    if (right_i.fall) begin
      dir_edge = DIR_RIGHT;
    end else if (left_i.fall) begin
      dir_edge = DIR_LEFT;
    end else begin
      dir_edge = dir_q;
    end

    neutral = left_i.stable && right_i.stable && (dir_edge != DIR_NEUTRAL) &&
              (since_inc > cooldown_ticks_i);

    tap_left_o  = left_i.fall  || (neutral && (dir_edge == DIR_LEFT));
    tap_right_o = right_i.fall || (neutral && (dir_edge == DIR_RIGHT));

    dir_d   = neutral ? DIR_NEUTRAL : dir_edge;
    since_d = neutral ? '0 : since_inc;
    direction_o = dir_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DIR_NEUTRAL;
      since_q <= '0;
    end else if (advance_i) begin
      dir_q   <= dir_d;
      since_q <= since_d;
    end
  end

endmodule

[hdl/turn_stalk_debounce_tapper_core.sv]
// ----------------------------------------------------------------------------
// turn_stalk_debounce_tapper_core
// Debounces the left/right turn stalk contacts and generates button taps.
// ----------------------------------------------------------------------------
// One item is one millisecond tick carrying the raw contact levels. Items
// pass an input register, combinational debounce and direction logic, and a
// result register. One item is taken every cycle unless the result side
// stalls; the per-tick state update (debounce counters, direction latch and
// cooldown counter) closes within that logic stage. Stall on the result side
// holds the result register and, once the input register is also full,
// stalls the input. Write the configuration registers only while idle.
module turn_stalk_debounce_tapper_core
  import tsdt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o
);

  logic [QuietW-1:0]    debounce_q;
  logic [CooldownW-1:0] cooldown_q;

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;
  logic        out_free, advance;
  deb_status_t left_st, right_st;
  logic        tap_left, tap_right;
  dir_e        direction;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
      cooldown_q <= CooldownReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DEBOUNCE) begin
        debounce_q <= cfg_data_i[QuietW-1:0];
      end else if (cfg_idx_i == CFG_COOLDOWN) begin
        cooldown_q <= cfg_data_i[CooldownW-1:0];
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  tsdt_debounce u_deb_left (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .raw_i            (in_item_q.raw_left),
    .debounce_ticks_i (debounce_q),
    .status_o         (left_st)
  );

  tsdt_debounce u_deb_right (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .raw_i            (in_item_q.raw_right),
    .debounce_ticks_i (debounce_q),
    .status_o         (right_st)
  );

  tsdt_direction u_dir (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .left_i           (left_st),
    .right_i          (right_st),
    .cooldown_ticks_i (cooldown_q),
    .tap_left_o       (tap_left),
    .tap_right_o      (tap_right),
    .direction_o      (direction)
  );

  always_comb begin
    out_item_d.tap_left     = tap_left;
    out_item_d.tap_right    = tap_right;
    out_item_d.hold_pressed = !in_item_q.raw_hold;
    out_item_d.direction    = direction;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hdl/tsdt_checker.sv]
// ----------------------------------------------------------------------------
// tsdt_checker
// Port-level checks for the turn stalk debounce tapper.
// ----------------------------------------------------------------------------
module tsdt_checker
  import tsdt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input out_item_t           out_item_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // the input only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // a lone left tap never leaves the direction at right
  a_left_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.tap_left && !out_item_o.tap_right |->
      out_item_o.direction != DIR_RIGHT)
    else $error("left tap with right direction");

  // a lone right tap never leaves the direction at left
  a_right_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.tap_right && !out_item_o.tap_left |->
      out_item_o.direction != DIR_LEFT)
    else $error("right tap with left direction");

endmodule

bind turn_stalk_debounce_tapper_core tsdt_checker u_tsdt_checker (.*);
